[rtl/uhpc_pkg.sv]
// shared types, codes and constants of the uplink harq process control block
package uhpc_pkg;

	localparam int NUM_PROCS   = 16;
	localparam int PROC_ID_W   = 4;
	localparam int PROC_IDX_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int RNTI_W      = 16;
	localparam int TBS_W       = 18;
	localparam int CNT_W       = 8;
	localparam int TOTAL_W     = 32;
	localparam int BITS_W      = 48;
	localparam int BYTE_SHIFT  = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0]       NDI_UNSET    = 2'd2;
	localparam logic [CNT_W-1:0] MAX_TX_RESET = 8'd4;

	typedef enum logic [2:0] {
		OP_GRANT   = 3'd0,
		OP_FLUSH   = 3'd1,
		OP_CLR_NDI = 3'd2,
		OP_STATS   = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_NEW     = 3'd0,
		ST_RETX    = 3'd1,
		ST_NOPDU   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_BADID   = 3'd4,
		ST_SCHED   = 3'd5,
		ST_UNKNOWN = 3'd6,
		ST_DONE    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CFG_CELL_RNTI  = 2'd0,
		CFG_TEMP_RNTI  = 2'd1,
		CFG_SCHED_RNTI = 2'd2,
		CFG_MAX_TX     = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		K_GRANT,
		K_SCHED,
		K_FOREIGN,
		K_FLUSH,
		K_CLR_NDI,
		K_STATS,
		K_QUERY,
		K_BAD_ID,
		K_BAD_OP
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [PROC_ID_W-1:0] proc_id;
		logic                 ndi;
		logic [1:0]           rv;
		logic [TBS_W-1:0]     tbs;
		logic                 is_rar;
		logic                 pdu;
		logic                 is_temp;
		logic                 is_cell;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic               tx_enable;
		logic [1:0]         rv_out;
		logic [TBS_W-1:0]   size_out;
		logic [CNT_W-1:0]   tx_number;
		logic               max_reached;
		logic [TOTAL_W-1:0] new_tx_total;
		logic [TOTAL_W-1:0] retx_total;
		logic [BITS_W-1:0]  bits_total;
	} res_t;

	typedef struct packed {
		logic [RNTI_W-1:0] cell_rnti;
		logic [RNTI_W-1:0] temp_rnti;
		logic [RNTI_W-1:0] sched_rnti;
		logic [CNT_W-1:0]  max_tx;
	} cfg_t;

endpackage

[rtl/uhpc_front.sv]
// front end: decodes and classifies each incoming word into a command
module uhpc_front (
	input  logic                           valid,
	input  logic [2:0]                     op,
	input  logic [uhpc_pkg::PROC_ID_W-1:0] proc_id,
	input  logic [uhpc_pkg::RNTI_W-1:0]    rnti,
	input  logic                           ndi,
	input  logic [1:0]                     rv,
	input  logic [uhpc_pkg::TBS_W-1:0]     tbs,
	input  logic                           is_rar,
	input  logic                           pdu_available,
	input  uhpc_pkg::cfg_t                 cfg,
	input  logic                           q_ready,
	output logic                           ready,
	output logic                           push,
	output uhpc_pkg::cmd_t                 cmd
);

	logic bad_id;
	logic is_cell;
	logic is_temp;
	logic is_sched;

	assign bad_id   = {1'b0, proc_id} >= (uhpc_pkg::PROC_ID_W + 1)'(uhpc_pkg::NUM_PROCS);
	assign is_cell  = rnti == cfg.cell_rnti;
	assign is_temp  = rnti == cfg.temp_rnti;
	assign is_sched = rnti == cfg.sched_rnti;

	assign ready = q_ready;
	assign push  = valid && q_ready;

	always_comb begin
		cmd         = '0;
		cmd.proc_id = proc_id;
		cmd.ndi     = ndi;
		cmd.rv      = rv;
		cmd.tbs     = tbs;
		cmd.is_rar  = is_rar;
		cmd.pdu     = pdu_available;
		cmd.is_temp = is_temp;
		cmd.is_cell = is_cell;
		case (op)
			uhpc_pkg::OP_GRANT: begin
				if (bad_id) begin
					cmd.kind = uhpc_pkg::K_BAD_ID;
				end else if (is_cell || is_temp || is_rar) begin
					cmd.kind = uhpc_pkg::K_GRANT;
				end else if (is_sched) begin
					cmd.kind = uhpc_pkg::K_SCHED;
				end else begin
					cmd.kind = uhpc_pkg::K_FOREIGN;
				end
			end
			uhpc_pkg::OP_FLUSH:   cmd.kind = uhpc_pkg::K_FLUSH;
			uhpc_pkg::OP_CLR_NDI: cmd.kind = uhpc_pkg::K_CLR_NDI;
			uhpc_pkg::OP_STATS:   cmd.kind = uhpc_pkg::K_STATS;
			uhpc_pkg::OP_QUERY: begin
				cmd.kind = bad_id ? uhpc_pkg::K_BAD_ID : uhpc_pkg::K_QUERY;
			end
			default:              cmd.kind = uhpc_pkg::K_BAD_OP;
		endcase
	end

endmodule

[rtl/uhpc_queue.sv]
// short command queue between the front end and the process table
module uhpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uhpc_pkg::cmd_t push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output uhpc_pkg::cmd_t head
);

	uhpc_pkg::cmd_t                  slot_q [uhpc_pkg::QUEUE_DEPTH];
	logic [uhpc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [uhpc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [uhpc_pkg::QCNT_W-1:0]     count_q;

	assign ready = count_q != uhpc_pkg::QCNT_W'(uhpc_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == uhpc_pkg::QPTR_W'(uhpc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == uhpc_pkg::QPTR_W'(uhpc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= uhpc_pkg::QCNT_W'(uhpc_pkg::QUEUE_DEPTH)) && !(pop && !valid))
		else $error("queue count out of range or pop while empty");
`endif

endmodule

[rtl/uhpc_back.sv]
// back end: process table, statistics counters and result register
module uhpc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  uhpc_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  uhpc_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output uhpc_pkg::res_t res
);

	logic [1:0]                    ndi_q  [uhpc_pkg::NUM_PROCS];
	logic [uhpc_pkg::CNT_W-1:0]    cnt_q  [uhpc_pkg::NUM_PROCS];
	logic [uhpc_pkg::TBS_W-1:0]    size_q [uhpc_pkg::NUM_PROCS];
	logic [uhpc_pkg::NUM_PROCS-1:0] held_q;
	logic [uhpc_pkg::TOTAL_W-1:0]  new_cnt_q;
	logic [uhpc_pkg::TOTAL_W-1:0]  retx_cnt_q;
	logic [uhpc_pkg::BITS_W-1:0]   bits_q;
	uhpc_pkg::res_t                res_q;
	logic                          valid_q;

	logic [uhpc_pkg::PROC_IDX_W-1:0] idx;
	logic [1:0]                   ndi_r;
	logic [uhpc_pkg::CNT_W-1:0]   cnt_r;
	logic [uhpc_pkg::TBS_W-1:0]   size_r;
	logic                         held_r;
	logic                         toggled;
	logic                         hit_max;
	logic [1:0]                   ndi_a;
	logic [uhpc_pkg::CNT_W-1:0]   cnt_a;
	logic [uhpc_pkg::TBS_W-1:0]   size_a;
	logic                         held_a;
	logic                         new_cond;
	logic [1:0]                   keep_ndi;
	logic [1:0]                   ndi_n;
	logic [uhpc_pkg::CNT_W-1:0]   cnt_n;
	logic [uhpc_pkg::TBS_W-1:0]   size_n;
	logic                         held_n;
	logic                         add_new;
	logic                         add_retx;
	uhpc_pkg::res_t               res_d;

	assign pop       = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign res       = res_q;

	assign idx    = cmd.proc_id[uhpc_pkg::PROC_IDX_W-1:0];
	assign ndi_r  = ndi_q[idx];
	assign cnt_r  = cnt_q[idx];
	assign size_r = size_q[idx];
	assign held_r = held_q[idx];

	assign toggled  = {1'b0, cmd.ndi} != ndi_r;
	assign hit_max  = cnt_r >= cfg.max_tx;
	assign ndi_a    = hit_max ? uhpc_pkg::NDI_UNSET : ndi_r;
	assign cnt_a    = hit_max ? '0 : cnt_r;
	assign size_a   = hit_max ? '0 : size_r;
	assign held_a   = hit_max ? 1'b0 : held_r;
	assign new_cond = (!cmd.is_temp && toggled) || (cmd.is_cell && !held_a) || cmd.is_rar;
	assign keep_ndi = (cmd.is_rar || cmd.is_temp) ? uhpc_pkg::NDI_UNSET : {1'b0, cmd.ndi};

	// grant decision on the named process, and the result word for every other command
	always_comb begin
		ndi_n    = ndi_a;
		cnt_n    = cnt_a;
		size_n   = size_a;
		held_n   = held_a;
		add_new  = 1'b0;
		add_retx = 1'b0;
		res_d    = '0;
		case (cmd.kind)
			uhpc_pkg::K_GRANT: begin
				res_d.max_reached = hit_max;
				if (new_cond) begin
					held_n = cmd.pdu;
					if (cmd.pdu) begin
						size_n          = cmd.tbs;
						ndi_n           = keep_ndi;
						cnt_n           = uhpc_pkg::CNT_W'(1);
						add_new         = 1'b1;
						res_d.status    = uhpc_pkg::ST_NEW;
						res_d.tx_enable = 1'b1;
						res_d.rv_out    = cmd.rv;
					end else begin
						res_d.status = uhpc_pkg::ST_NOPDU;
					end
				end else if (!held_a) begin
					res_d.status = uhpc_pkg::ST_EMPTY;
				end else begin
					size_n          = cmd.tbs;
					ndi_n           = keep_ndi;
					cnt_n           = cnt_a + 1'b1;
					add_retx        = 1'b1;
					res_d.status    = uhpc_pkg::ST_RETX;
					res_d.tx_enable = 1'b1;
					res_d.rv_out    = cmd.rv;
				end
				res_d.size_out  = size_n;
				res_d.tx_number = cnt_n;
			end
			uhpc_pkg::K_SCHED: begin
				res_d.status    = uhpc_pkg::ST_SCHED;
				res_d.size_out  = size_r;
				res_d.tx_number = cnt_r;
			end
			uhpc_pkg::K_FOREIGN: begin
				res_d.status    = uhpc_pkg::ST_UNKNOWN;
				res_d.size_out  = size_r;
				res_d.tx_number = cnt_r;
			end
			uhpc_pkg::K_FLUSH:   res_d.status = uhpc_pkg::ST_DONE;
			uhpc_pkg::K_CLR_NDI: res_d.status = uhpc_pkg::ST_DONE;
			uhpc_pkg::K_STATS: begin
				res_d.status       = uhpc_pkg::ST_DONE;
				res_d.new_tx_total = new_cnt_q;
				res_d.retx_total   = retx_cnt_q;
				res_d.bits_total   = bits_q;
			end
			uhpc_pkg::K_QUERY: begin
				res_d.status   = uhpc_pkg::ST_DONE;
				res_d.size_out = size_r;
			end
			uhpc_pkg::K_BAD_ID:  res_d.status = uhpc_pkg::ST_BADID;
			default:             res_d.status = uhpc_pkg::ST_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < uhpc_pkg::NUM_PROCS; p++) begin
				ndi_q[p]  <= uhpc_pkg::NDI_UNSET;
				cnt_q[p]  <= '0;
				size_q[p] <= '0;
			end
			held_q     <= '0;
			new_cnt_q  <= '0;
			retx_cnt_q <= '0;
			bits_q     <= '0;
		end else if (pop) begin
			case (cmd.kind)
				uhpc_pkg::K_GRANT: begin
					ndi_q[idx]  <= ndi_n;
					cnt_q[idx]  <= cnt_n;
					size_q[idx] <= size_n;
					held_q[idx] <= held_n;
					if (add_new) begin
						new_cnt_q <= new_cnt_q + 1'b1;
					end
					if (add_retx) begin
						retx_cnt_q <= retx_cnt_q + 1'b1;
					end
					if (add_new || add_retx) begin
						bits_q <= bits_q + (uhpc_pkg::BITS_W'(cmd.tbs) << uhpc_pkg::BYTE_SHIFT);
					end
				end
				uhpc_pkg::K_FLUSH: begin
					for (int p = 0; p < uhpc_pkg::NUM_PROCS; p++) begin
						ndi_q[p]  <= uhpc_pkg::NDI_UNSET;
						cnt_q[p]  <= '0;
						size_q[p] <= '0;
					end
					held_q <= '0;
				end
				uhpc_pkg::K_CLR_NDI: begin
					for (int p = 0; p < uhpc_pkg::NUM_PROCS; p++) begin
						ndi_q[p] <= uhpc_pkg::NDI_UNSET;
					end
				end
				uhpc_pkg::K_STATS: begin
					new_cnt_q  <= '0;
					retx_cnt_q <= '0;
					bits_q     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_new_tx_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.status == uhpc_pkg::ST_NEW) |->
			(res_q.tx_number == uhpc_pkg::CNT_W'(1)))
		else $error("new transmission without a count of one");

	a_tx_enable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (res_q.tx_enable ==
			(res_q.status == uhpc_pkg::ST_NEW || res_q.status == uhpc_pkg::ST_RETX)))
		else $error("tx enable does not match status");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.kind == uhpc_pkg::K_FLUSH) |=> (held_q == '0))
		else $error("buffer still held after flush");

	a_stats_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.kind == uhpc_pkg::K_STATS) |=>
			(new_cnt_q == '0 && retx_cnt_q == '0 && bits_q == '0))
		else $error("counters not cleared after read");
`endif

endmodule

[rtl/uplink_harq_process_control.sv]
// top level of the uplink harq process control block
//
// channel  | direction | word
// s_*      | in        | tuser: op[2:0] is_rar[3]; tdata: proc_id rnti ndi rv tbs pdu_available
// m_*      | out       | tuser: status[2:0]; tdata: grant result and statistics
// cfg_*    | in        | register write, index 0..3, no read-back
//
// one word per cycle while m_tready holds high; results pass the queue, then the result register
// the decision on the process table is made combinationally in the back end
// a two-word queue parts the decoder from the table; with m_tready low it fills and s_tready drops
// reset clears the table, the counters and both handshakes at once; no clearing pass
module uplink_harq_process_control (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,  // proc_id, rnti, ndi, rv, tbs, pdu_available, zero pad
	input  logic [3:0]   s_tuser,  // op, is_rar
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // tx_enable, rv_out, size_out, tx_number, max_reached,
	                               // new_tx_total, retx_total, bits_total, zero pad
	output logic [2:0]   m_tuser,  // status
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [uhpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	uhpc_pkg::cfg_t cfg_q;
	uhpc_pkg::cmd_t front_cmd;
	uhpc_pkg::cmd_t q_head;
	uhpc_pkg::res_t res;
	logic           q_ready;
	logic           q_valid;
	logic           push;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_rnti  <= '0;
			cfg_q.temp_rnti  <= '0;
			cfg_q.sched_rnti <= '0;
			cfg_q.max_tx     <= uhpc_pkg::MAX_TX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				uhpc_pkg::CFG_CELL_RNTI:  cfg_q.cell_rnti  <= cfg_wdata;
				uhpc_pkg::CFG_TEMP_RNTI:  cfg_q.temp_rnti  <= cfg_wdata;
				uhpc_pkg::CFG_SCHED_RNTI: cfg_q.sched_rnti <= cfg_wdata;
				uhpc_pkg::CFG_MAX_TX:     cfg_q.max_tx     <= cfg_wdata[uhpc_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	uhpc_front u_front (
		.valid         (s_tvalid),
		.op            (s_tuser[2:0]),
		.proc_id       (s_tdata[3:0]),
		.rnti          (s_tdata[19:4]),
		.ndi           (s_tdata[20]),
		.rv            (s_tdata[22:21]),
		.tbs           (s_tdata[40:23]),
		.is_rar        (s_tuser[3]),
		.pdu_available (s_tdata[41]),
		.cfg           (cfg_q),
		.q_ready       (q_ready),
		.ready         (s_tready),
		.push          (push),
		.cmd           (front_cmd)
	);

	uhpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	uhpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.cmd       (q_head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {2'b00, res.bits_total, res.retx_total, res.new_tx_total, res.max_reached,
		res.tx_number, res.size_out, res.rv_out, res.tx_enable};

endmodule
